@@ hw/rtl/tscd_pkg.sv @@
// Package for the thumb-shift chord decoder: chord states, key ids, HID codes
// and the kana romanization ROM as constant functions. No dependencies.
package tscd_pkg;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_M    = 5'b00010,
        ST_O    = 5'b00100,
        ST_MO   = 5'b01000,
        ST_OM   = 5'b10000
    } chord_state_t;

    localparam logic [5:0] KEY_LAST_CHAR = 6'd32;
    localparam logic [5:0] KEY_LTHUMB    = 6'd33;
    localparam logic [5:0] KEY_RTHUMB    = 6'd34;
    localparam logic [5:0] KEY_ON        = 6'd35;
    localparam logic [5:0] KEY_OFF       = 6'd36;
    localparam logic [5:0] KEY_MOD       = 6'd37;

    localparam logic [1:0] THUMB_NONE  = 2'd0;
    localparam logic [1:0] THUMB_LEFT  = 2'd1;
    localparam logic [1:0] THUMB_RIGHT = 2'd2;

    localparam logic [15:0] TIMEOUT_RESET = 16'd150;
    localparam logic [15:0] OVERLAP_RESET = 16'd20;
    localparam logic [3:0]  MOD_MAX       = 4'd15;

    localparam logic [0:0] CFG_TIMEOUT = 1'b0;
    localparam logic [0:0] CFG_OVERLAP = 1'b1;

    localparam logic [7:0] HID_SPC   = 8'h2C;
    localparam logic [7:0] HID_SLSH  = 8'h38;
    localparam logic [7:0] HID_LANG1 = 8'h90;
    localparam logic [7:0] HID_LANG2 = 8'h91;
    localparam logic [7:0] HID_BSPC  = 8'h2A;

    // One ROM entry: up to three codes and whether the first is shifted.
    typedef struct packed {
        logic [1:0] count;
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic       shift;
    } taps_t;

    // Letter a-z as HID usage.
    function automatic logic [7:0] lt(input logic [7:0] ch);
        lt = 8'h04 + (ch - 8'h61);
    endfunction

    function automatic taps_t t1(input logic [7:0] a);
        t1 = '{count: 2'd1, c0: a, c1: 8'h00, c2: 8'h00, shift: 1'b0};
    endfunction

    function automatic taps_t t2(input logic [7:0] a, input logic [7:0] b);
        t2 = '{count: 2'd2, c0: a, c1: b, c2: 8'h00, shift: 1'b0};
    endfunction

    function automatic taps_t t3(input logic [7:0] a, input logic [7:0] b,
                                 input logic [7:0] c);
        t3 = '{count: 2'd3, c0: a, c1: b, c2: c, shift: 1'b0};
    endfunction

    function automatic taps_t rom_single(input logic [5:0] k);
        taps_t r;
        r = '0;
        case (k)
            6'd0:  r = t1(8'h37);
            6'd1:  r = t2(lt("k"), lt("a"));
            6'd2:  r = t2(lt("t"), lt("a"));
            6'd3:  r = t2(lt("k"), lt("o"));
            6'd4:  r = t2(lt("s"), lt("a"));
            6'd5:  r = t2(lt("r"), lt("a"));
            6'd6:  r = t2(lt("t"), lt("i"));
            6'd7:  r = t2(lt("k"), lt("u"));
            6'd8:  r = t2(lt("t"), lt("u"));
            6'd9:  r = t1(8'h36);
            6'd10: r = t1(8'h36);
            6'd11: r = t1(8'h33);
            6'd12: r = t1(lt("u"));
            6'd13: r = t2(lt("s"), lt("i"));
            6'd14: r = t2(lt("t"), lt("e"));
            6'd15: r = t2(lt("k"), lt("e"));
            6'd16: r = t2(lt("s"), lt("e"));
            6'd17: r = t2(lt("h"), lt("a"));
            6'd18: r = t2(lt("t"), lt("o"));
            6'd19: r = t2(lt("k"), lt("i"));
            6'd20: r = t1(lt("i"));
            6'd21: r = t2(lt("n"), lt("n"));
            6'd22: r = t1(HID_BSPC);
            6'd23: r = t1(8'h37);
            6'd24: r = t2(lt("h"), lt("i"));
            6'd25: r = t2(lt("s"), lt("u"));
            6'd26: r = t2(lt("h"), lt("u"));
            6'd27: r = t2(lt("h"), lt("e"));
            6'd28: r = t2(lt("m"), lt("e"));
            6'd29: r = t2(lt("s"), lt("o"));
            6'd30: r = t2(lt("n"), lt("e"));
            6'd31: r = t2(lt("h"), lt("o"));
            6'd32: r = t1(HID_SLSH);
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic taps_t rom_left(input logic [5:0] k);
        taps_t r;
        r = '0;
        case (k)
            6'd0:  r = t2(lt("x"), lt("a"));
            6'd1:  r = t1(lt("e"));
            6'd2:  r = t2(lt("r"), lt("i"));
            6'd3:  r = t3(lt("x"), lt("y"), lt("a"));
            6'd4:  r = t2(lt("r"), lt("e"));
            6'd5:  r = t2(lt("p"), lt("a"));
            6'd6:  r = t2(lt("d"), lt("i"));
            6'd7:  r = t2(lt("g"), lt("u"));
            6'd8:  r = t2(lt("d"), lt("u"));
            6'd9:  r = t2(lt("p"), lt("i"));
            6'd10: r = t1(8'h2F);
            6'd11: r = t1(8'h30);
            6'd12: r = t2(lt("w"), lt("o"));
            6'd13: r = t1(lt("a"));
            6'd14: r = t2(lt("n"), lt("a"));
            6'd15: r = t3(lt("x"), lt("y"), lt("u"));
            6'd16: r = t2(lt("m"), lt("o"));
            6'd17: r = t2(lt("b"), lt("a"));
            6'd18: r = t2(lt("d"), lt("o"));
            6'd19: r = t2(lt("g"), lt("i"));
            6'd20: r = t2(lt("p"), lt("o"));
            6'd22: r = t1(HID_BSPC);
            6'd23: r = t2(lt("x"), lt("u"));
            6'd24: r = t1(8'h2D);
            6'd25: r = t2(lt("r"), lt("o"));
            6'd26: r = t2(lt("y"), lt("a"));
            6'd27: r = t2(lt("x"), lt("o"));
            6'd28: r = t2(lt("p"), lt("u"));
            6'd29: r = t2(lt("z"), lt("o"));
            6'd30: r = t2(lt("p"), lt("e"));
            6'd31: r = t2(lt("b"), lt("o"));
            6'd32: r = '{count: 2'd1, c0: HID_SLSH, c1: 8'h00, c2: 8'h00, shift: 1'b1};
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic taps_t rom_right(input logic [5:0] k);
        taps_t r;
        r = '0;
        case (k)
            6'd1:  r = t2(lt("g"), lt("a"));
            6'd2:  r = t2(lt("d"), lt("a"));
            6'd3:  r = t2(lt("g"), lt("o"));
            6'd4:  r = t2(lt("z"), lt("a"));
            6'd5:  r = t2(lt("y"), lt("o"));
            6'd6:  r = t2(lt("n"), lt("i"));
            6'd7:  r = t2(lt("r"), lt("u"));
            6'd8:  r = t2(lt("m"), lt("a"));
            6'd9:  r = t2(lt("x"), lt("e"));
            6'd10: r = t1(8'h2F);
            6'd11: r = t1(8'h30);
            6'd12: r = t2(lt("v"), lt("u"));
            6'd13: r = t2(lt("z"), lt("i"));
            6'd14: r = t2(lt("d"), lt("e"));
            6'd15: r = t2(lt("g"), lt("e"));
            6'd16: r = t2(lt("z"), lt("e"));
            6'd17: r = t2(lt("m"), lt("i"));
            6'd18: r = t1(lt("o"));
            6'd19: r = t2(lt("n"), lt("o"));
            6'd20: r = t3(lt("x"), lt("y"), lt("o"));
            6'd21: r = t3(lt("x"), lt("t"), lt("u"));
            6'd22: r = t1(8'h34);
            6'd24: r = t2(lt("b"), lt("i"));
            6'd25: r = t2(lt("z"), lt("u"));
            6'd26: r = t2(lt("b"), lt("u"));
            6'd27: r = t2(lt("b"), lt("e"));
            6'd28: r = t2(lt("n"), lt("u"));
            6'd29: r = t2(lt("y"), lt("u"));
            6'd30: r = t2(lt("m"), lt("u"));
            6'd31: r = t2(lt("w"), lt("a"));
            6'd32: r = t2(lt("x"), lt("o"));
            default: r = '0;
        endcase
        return r;
    endfunction

    // What the chord machine decided to type this event.
    typedef enum logic [3:0] {
        EMIT_NONE  = 4'b0001,
        EMIT_CHAR  = 4'b0010,
        EMIT_THUMB = 4'b0100,
        EMIT_COMBO = 4'b1000
    } emit_t;

    // Decision handed from the chord machine to the tap encoder.
    typedef struct packed {
        emit_t      emit;
        logic       lang;
        logic [7:0] lang_code;
        logic [5:0] chr;
        logic [1:0] thumb;
        logic       layer;
    } decision_t;

endpackage

@@ hw/rtl/tscd_chord_fsm.sv @@
// Chord state machine: holds the engaged/overlay/modifier state and the pending
// chord, and decides what is typed for each event. Depends on tscd_pkg.
module tscd_chord_fsm
    import tscd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [5:0]  key_id,
    input  logic        pressed,
    input  logic [15:0] time_ms,
    input  logic [15:0] timeout_reg,
    input  logic [15:0] overlap_reg,
    output decision_t   dec
);

    logic         engaged_reg, engaged_next;
    logic         overlay_reg, overlay_next;
    chord_state_t state_reg, state_next;
    logic [5:0]   char_reg, char_next;
    logic [1:0]   thumb_reg, thumb_next;
    logic [15:0]  cstamp_reg, cstamp_next;
    logic [15:0]  tstamp_reg, tstamp_next;
    logic [3:0]   mods_reg, mods_next;

    logic [15:0] g_now_t, g_now_c, g_t_c, g_c_t;
    logic        is_char, is_thumb;
    emit_t       emit;

    assign g_now_t = time_ms - tstamp_reg;
    assign g_now_c = time_ms - cstamp_reg;
    assign g_t_c   = tstamp_reg - cstamp_reg;
    assign g_c_t   = cstamp_reg - tstamp_reg;

    assign is_char  = (key_id <= KEY_LAST_CHAR) && (char_reg == key_id);
    assign is_thumb = (thumb_reg == THUMB_LEFT && key_id == KEY_LTHUMB) ||
                      (thumb_reg == THUMB_RIGHT && key_id == KEY_RTHUMB);

    always_comb
    begin
        engaged_next = engaged_reg;
        overlay_next = overlay_reg;
        state_next   = state_reg;
        char_next    = char_reg;
        thumb_next   = thumb_reg;
        cstamp_next  = cstamp_reg;
        tstamp_next  = tstamp_reg;
        mods_next    = mods_reg;
        emit         = EMIT_NONE;
        dec          = '0;
        dec.emit     = EMIT_NONE;

        if (key_id == KEY_ON || key_id == KEY_OFF) begin
            if (pressed) begin
                dec.lang      = 1'b1;
                dec.lang_code = (key_id == KEY_ON) ? HID_LANG1 : HID_LANG2;
                engaged_next  = (key_id == KEY_ON);
                overlay_next  = (key_id == KEY_ON);
                state_next    = ST_IDLE;
            end
        end else if (key_id <= KEY_RTHUMB && overlay_reg) begin
            if (pressed && key_id <= KEY_LAST_CHAR) begin
                case (state_reg)
                    ST_IDLE: state_next = ST_M;
                    ST_M:    emit = EMIT_CHAR;
                    ST_O:
                    begin
                        if (g_now_t > timeout_reg) begin
                            emit = EMIT_THUMB;
                            state_next = ST_M;
                        end else begin
                            state_next = ST_OM;
                        end
                    end
                    ST_MO:
                    begin
                        if (g_now_t > timeout_reg || g_t_c < g_now_t) begin
                            emit = EMIT_COMBO;
                            state_next = ST_M;
                        end else begin
                            emit = EMIT_CHAR;
                            state_next = ST_OM;
                        end
                    end
                    ST_OM:
                    begin
                        emit = EMIT_COMBO;
                        state_next = ST_M;
                    end
                    default: state_next = ST_IDLE;
                endcase
                char_next   = key_id;
                cstamp_next = time_ms;
            end else if (pressed) begin
                case (state_reg)
                    ST_IDLE: state_next = ST_O;
                    ST_M:
                    begin
                        if (g_now_c > timeout_reg) begin
                            emit = EMIT_CHAR;
                            state_next = ST_O;
                        end else begin
                            state_next = ST_MO;
                        end
                    end
                    ST_O:    emit = EMIT_THUMB;
                    ST_MO:
                    begin
                        emit = EMIT_COMBO;
                        state_next = ST_O;
                    end
                    ST_OM:
                    begin
                        if (g_now_c > timeout_reg || g_c_t < g_now_c) begin
                            emit = EMIT_COMBO;
                            state_next = ST_O;
                        end else begin
                            emit = EMIT_THUMB;
                            state_next = ST_MO;
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
                thumb_next  = (key_id == KEY_LTHUMB) ? THUMB_LEFT : THUMB_RIGHT;
                tstamp_next = time_ms;
            end else begin
                case (state_reg)
                    ST_M:
                    begin
                        if (is_char) begin
                            emit = EMIT_CHAR;
                            state_next = ST_IDLE;
                        end
                    end
                    ST_O:
                    begin
                        if (is_thumb) begin
                            emit = EMIT_THUMB;
                            state_next = ST_IDLE;
                        end
                    end
                    ST_MO:
                    begin
                        if (is_char) begin
                            if (g_t_c >= g_now_t && g_now_t < overlap_reg) begin
                                emit = EMIT_CHAR;
                                state_next = ST_O;
                            end else begin
                                emit = EMIT_COMBO;
                                state_next = ST_IDLE;
                            end
                        end else if (is_thumb) begin
                            emit = EMIT_COMBO;
                            state_next = ST_IDLE;
                        end
                    end
                    ST_OM:
                    begin
                        if (is_thumb) begin
                            if (g_c_t >= g_now_c && g_now_c < overlap_reg) begin
                                emit = EMIT_THUMB;
                                state_next = ST_M;
                            end else begin
                                emit = EMIT_COMBO;
                                state_next = ST_IDLE;
                            end
                        end else if (is_char) begin
                            emit = EMIT_COMBO;
                            state_next = ST_IDLE;
                        end
                    end
                    default: state_next = state_reg;
                endcase
            end
        end else if (engaged_reg) begin
            if (pressed) begin
                // A plain key types whatever chord is pending first.
                case (state_reg)
                    ST_M:    emit = EMIT_CHAR;
                    ST_O:    emit = EMIT_THUMB;
                    ST_MO:   emit = EMIT_COMBO;
                    ST_OM:   emit = EMIT_COMBO;
                    default: emit = EMIT_NONE;
                endcase
                state_next = ST_IDLE;
                if (key_id == KEY_MOD) begin
                    if (mods_reg == 4'd0) overlay_next = 1'b0;
                    if (mods_reg != MOD_MAX) mods_next = mods_reg + 4'd1;
                end
            end else if (key_id == KEY_MOD) begin
                if (mods_reg <= 4'd1) begin
                    mods_next    = 4'd0;
                    overlay_next = 1'b1;
                end else begin
                    mods_next = mods_reg - 4'd1;
                end
            end
        end

        dec.emit  = emit;
        dec.chr   = char_reg;
        dec.thumb = thumb_reg;
        dec.layer = overlay_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            engaged_reg <= 1'b0;
            overlay_reg <= 1'b0;
            state_reg   <= ST_IDLE;
            char_reg    <= 6'd0;
            thumb_reg   <= THUMB_NONE;
            cstamp_reg  <= 16'd0;
            tstamp_reg  <= 16'd0;
            mods_reg    <= 4'd0;
        end else if (step) begin
            engaged_reg <= engaged_next;
            overlay_reg <= overlay_next;
            state_reg   <= state_next;
            char_reg    <= char_next;
            thumb_reg   <= thumb_next;
            cstamp_reg  <= cstamp_next;
            tstamp_reg  <= tstamp_next;
            mods_reg    <= mods_next;
        end
    end

endmodule

@@ hw/rtl/tscd_tap_encoder.sv @@
// Tap encoder: turns a chord decision into up to three HID codes using the
// romanization ROM functions. Depends on tscd_pkg.
module tscd_tap_encoder
    import tscd_pkg::*;
(
    input  decision_t  dec,
    output logic [1:0] tap_count,
    output logic [7:0] first_code,
    output logic [7:0] second_code,
    output logic [7:0] third_code,
    output logic       shifted
);

    taps_t t;
    logic  valid_char;

    assign valid_char = (dec.chr <= KEY_LAST_CHAR);

    always_comb
    begin
        t = '0;
        if (dec.lang) begin
            t = t1(dec.lang_code);
        end else begin
            case (dec.emit)
                EMIT_CHAR:  t = valid_char ? rom_single(dec.chr) : '0;
                EMIT_THUMB: t = (dec.thumb != THUMB_NONE) ? t1(HID_SPC) : '0;
                EMIT_COMBO:
                begin
                    if (valid_char && dec.thumb == THUMB_LEFT)
                        t = rom_left(dec.chr);
                    else if (valid_char && dec.thumb == THUMB_RIGHT)
                        t = rom_right(dec.chr);
                end
                default: t = '0;
            endcase
        end
    end

    assign tap_count   = t.count;
    assign first_code  = t.c0;
    assign second_code = t.c1;
    assign third_code  = t.c2;
    assign shifted     = t.shift;

endmodule

@@ hw/rtl/thumb_shift_chord_decoder_unit.sv @@
// Top level of the thumb-shift chord decoder: input channel, configuration
// registers and the result register. Depends on tscd_pkg and the submodules.
//
// Usage:
// Key events enter on the input channel (key_id, pressed, time_ms) with
// in_valid/in_stall; an item is taken at a clock edge with in_valid high and
// in_stall low. Every event gives exactly one result item on the output
// channel (tap_count, three HID codes, shifted, layer_active) with
// out_valid/out_stall, taken when out_valid is high and out_stall low.
// The chord machine and the ROM lookup sit between the input ports and a
// single result register, so the block takes one item per cycle unless the
// output stalls. in_stall follows the result register only: while a result
// is held by a stalling receiver the block stalls its input, and when the
// result leaves the next item may be taken in that same cycle.
// Config: cfg_we writes cfg_data to register cfg_index (0 timeout, 1 overlap
// window, in ms) at the clock edge; only write while idle (not enforced).
// Reset (rst_n low, asynchronous) empties the result register, restores
// timeout 150 and overlap 20, and leaves the mode off with no chord pending.
module thumb_shift_chord_decoder_unit
    import tscd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [5:0]  key_id,
    input  logic        pressed,
    input  logic [15:0] time_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  tap_count,
    output logic [7:0]  first_code,
    output logic [7:0]  second_code,
    output logic [7:0]  third_code,
    output logic        shifted,
    output logic        layer_active,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0] timeout_reg, overlap_reg;
    logic        step;
    decision_t   dec;
    logic [1:0]  cnt;
    logic [7:0]  c0, c1, c2;
    logic        sh;
    logic        valid_reg;
    logic [1:0]  count_reg;
    logic [7:0]  c0_reg, c1_reg, c2_reg;
    logic        sh_reg, layer_reg;

    // The input moves whenever the result register is empty or being drained.
    assign in_stall = valid_reg && out_stall;
    assign step     = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            timeout_reg <= TIMEOUT_RESET;
            overlap_reg <= OVERLAP_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_TIMEOUT: timeout_reg <= cfg_data;
                CFG_OVERLAP: overlap_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    tscd_chord_fsm u_fsm (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .key_id      (key_id),
        .pressed     (pressed),
        .time_ms     (time_ms),
        .timeout_reg (timeout_reg),
        .overlap_reg (overlap_reg),
        .dec         (dec)
    );

    tscd_tap_encoder u_enc (
        .dec         (dec),
        .tap_count   (cnt),
        .first_code  (c0),
        .second_code (c1),
        .third_code  (c2),
        .shifted     (sh)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (step) begin
            valid_reg <= 1'b1;
        end else if (!out_stall) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step) begin
            count_reg <= cnt;
            c0_reg    <= c0;
            c1_reg    <= c1;
            c2_reg    <= c2;
            sh_reg    <= sh;
            layer_reg <= dec.layer;
        end
    end

    assign out_valid    = valid_reg;
    assign tap_count    = count_reg;
    assign first_code   = c0_reg;
    assign second_code  = c1_reg;
    assign third_code   = c2_reg;
    assign shifted      = sh_reg;
    assign layer_active = layer_reg;

endmodule

@@ hw/rtl/tscd_checker.sv @@
// Port-level checker for the thumb-shift chord decoder, bound to the top level.
// Depends on tscd_pkg only for the shared house style.
module tscd_checker
    import tscd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] tap_count,
    input logic [7:0] second_code,
    input logic [7:0] third_code,
    input logic       shifted
);

    // Input stalls only while a result is held back by the receiver.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held result");

    // An accepted item shows a result in the next cycle.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> out_valid)
        else $error("result missing after accepted item");

    // A held result does not change.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(tap_count)))
        else $error("stalled result changed");

    // Unused codes are zero (only the second at 0 taps); 0 taps means no shift.
    a_zero_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((tap_count == 2'd0 && !shifted && second_code == 8'd0) ||
                       (tap_count == 2'd1 && second_code == 8'd0 &&
                        third_code == 8'd0) ||
                       (tap_count == 2'd2 && third_code == 8'd0) ||
                       (tap_count == 2'd3)))
        else $error("code beyond tap count not zero");

endmodule

bind thumb_shift_chord_decoder_unit tscd_checker u_tscd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .tap_count   (tap_count),
    .second_code (second_code),
    .third_code  (third_code),
    .shifted     (shifted)
);
